// ===== rtl/rqpi_pkg.sv =====
`default_nettype none

package rqpi_pkg;

	localparam int VALUE_W   = 32;
	localparam int POS_W     = 5;
	localparam int COUNT_W   = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_INSERT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// What one cell does with its slot in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_NEXT = 2'd2,
		CELL_FROM_PREV = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] out_value;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rqpi_cell.sv =====
`default_nettype none

module rqpi_cell (
	input  wire                                     clk,
	input  wire rqpi_pkg::cell_op_t                 op,
	input  wire logic signed [rqpi_pkg::VALUE_W-1:0] prev_val,
	input  wire logic signed [rqpi_pkg::VALUE_W-1:0] next_val,
	input  wire logic signed [rqpi_pkg::VALUE_W-1:0] load_val,
	output logic signed [rqpi_pkg::VALUE_W-1:0]      val
);
	import rqpi_pkg::*;

	logic signed [VALUE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD:      val_q <= load_val;
			CELL_FROM_NEXT: val_q <= next_val;
			CELL_FROM_PREV: val_q <= prev_val;
			default:        val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

// ===== rtl/ring_queue_with_positional_insert.sv =====
`default_nettype none

// Channel | Valid     | Stall     | Payload        | Meaning
// --------+-----------+-----------+----------------+------------------------------
// request | req_valid | req_stall | req (req_t)    | push / pop / insert operation
// result  | rsp_valid | rsp_stall | rsp (rsp_t)    | status, popped value, count
//
// For every operation the row of cells shifts, loads or holds in the
// cycle the request transaction is accepted, and the result sits in
// an output register the next cycle. A new request is taken each cycle
// unless a finished result is still stalled. arst_n clears the count and
// the result valid; cell contents are not reset and are never shown unless
// written.

module ring_queue_with_positional_insert #(
	parameter int DEPTH = rqpi_pkg::DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire rqpi_pkg::req_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output rqpi_pkg::rsp_t     rsp
);
	import rqpi_pkg::*;

	// Count must be able to hold DEPTH itself.
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             cnt_next;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	rsp_t                      rsp_next;
	logic                      accept;
	logic                      full;
	logic                      empty;
	logic [CMP_W-1:0]          n_avail;
	logic [CMP_W-1:0]          pos_ext;
	logic [CMP_W-1:0]          ins_pos;
	mode_t                     mode;
	logic signed [VALUE_W-1:0] cell_val [DEPTH];
	cell_op_t                  cell_op  [DEPTH];

	// Hold the request side while a finished result waits to be taken.
	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	assign mode  = mode_t'(req.mode);
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	// A full insert drops the head first, so one fewer entry stays ahead.
	assign n_avail = full ? CMP_W'(DEPTH - 1) : CMP_W'(cnt_q);
	assign pos_ext = CMP_W'(req.position);
	assign ins_pos = (pos_ext < n_avail) ? pos_ext : n_avail;

	// Per-cell steering: cell 0 is the head, higher cells toward the tail.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [CMP_W-1:0]          idx;
		logic signed [VALUE_W-1:0] prev_v;
		logic signed [VALUE_W-1:0] next_v;

		assign idx = CMP_W'(i);

		if (i == 0) begin : g_first
			assign prev_v = cell_val[i];
		end else begin : g_mid_prev
			assign prev_v = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = cell_val[i];
		end else begin : g_mid_next
			assign next_v = cell_val[i+1];
		end

		always_comb begin
			cell_op[i] = CELL_HOLD;
			if (accept) begin
				case (mode)
					MODE_PUSH: begin
						// Load at the tail slot unless full.
						if (!full && (idx == CMP_W'(cnt_q))) begin
							cell_op[i] = CELL_LOAD;
						end
					end
					MODE_POP: begin
						// Advance every entry one place toward the head.
						if (!empty) begin
							cell_op[i] = CELL_FROM_NEXT;
						end
					end
					MODE_INSERT: begin
						if (idx == ins_pos) begin
							cell_op[i] = CELL_LOAD;
						end else if (full) begin
							// Head dropped: entries ahead of the slot move up.
							if (idx < ins_pos) begin
								cell_op[i] = CELL_FROM_NEXT;
							end
						end else if (idx > ins_pos) begin
							// Entries behind the slot move toward the tail.
							cell_op[i] = CELL_FROM_PREV;
						end
					end
					default: cell_op[i] = CELL_HOLD;
				endcase
			end
		end

		rqpi_cell u_cell (
			.clk      (clk),
			.op       (cell_op[i]),
			.prev_val (prev_v),
			.next_val (next_v),
			.load_val (req.value),
			.val      (cell_val[i])
		);
	end

	// Result and next count for the accepted operation.
	always_comb begin
		cnt_next           = cnt_q;
		rsp_next.status    = ST_OK;
		rsp_next.out_value = '0;
		case (mode)
			MODE_PUSH: begin
				if (full) begin
					rsp_next.status = ST_OVERFLOW;
				end else begin
					cnt_next = cnt_q + CW'(1);
				end
			end
			MODE_POP: begin
				if (empty) begin
					rsp_next.status = ST_EMPTY;
				end else begin
					rsp_next.out_value = cell_val[0];
					cnt_next           = cnt_q - CW'(1);
				end
			end
			MODE_INSERT: begin
				if (full) begin
					rsp_next.status = ST_OVERFLOW;
				end else begin
					cnt_next = cnt_q + CW'(1);
				end
			end
			default: cnt_next = cnt_q;
		endcase
		rsp_next.count = COUNT_W'(cnt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				// Drop the result once taken.
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
